>>> design/lbfd_pkg.sv
// Shared types and constants for the learning bridge forward decision unit.
package lbfd_pkg;

   localparam int MAC_W   = 48;
   localparam int PORT_W  = 3;
   localparam int MASK_W  = 4;
   localparam int ENTRY_W = MAC_W + PORT_W;

   localparam logic [MAC_W-1:0] BROADCAST_MAC = {MAC_W{1'b1}};

   typedef enum logic [1:0] {
      DEC_BCAST   = 2'd0,
      DEC_UNKNOWN = 2'd1,
      DEC_FILTER  = 2'd2,
      DEC_FORWARD = 2'd3
   } decision_type;

   typedef enum logic [1:0] {
      LRN_KNOWN = 2'd0,
      LRN_ADDED = 2'd1,
      LRN_MOVED = 2'd2,
      LRN_FULL  = 2'd3
   } learn_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DECIDE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;     // capture header, restart scan
      logic scan_rd;  // read table entry at scan pointer
      logic commit;   // update table, load result register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic count_zero;  // table holds no entries
      logic ptr_last;    // scan pointer is at the last filled entry
      logic out_free;    // result register can take a new result
      logic table_full;  // every entry in use
   } status_type;

endpackage

>>> design/lbfd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module lbfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/lbfd_ctrl.sv
// Sequencer for header capture, table scan, table update and result hand-off.
module lbfd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lbfd_pkg::status_type   status,
   output lbfd_pkg::cmd_type      cmd
);

   lbfd_pkg::state_type state_ff;
   lbfd_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbfd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         lbfd_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.count_zero ? lbfd_pkg::ST_DECIDE : lbfd_pkg::ST_SCAN;
            end
         end
         lbfd_pkg::ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            if (status.ptr_last) begin
               state_in = lbfd_pkg::ST_DRAIN;
            end
         end
         lbfd_pkg::ST_DRAIN: begin
            state_in = lbfd_pkg::ST_DECIDE;
         end
         lbfd_pkg::ST_DECIDE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = lbfd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lbfd_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

>>> design/lbfd_dp.sv
// Datapath: header registers, table RAM, scan compare, decision logic, result register.
module lbfd_dp #(
   parameter int PORTS         = 4,
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [lbfd_pkg::MAC_W-1:0]        req_src_mac,
   input  logic [lbfd_pkg::MAC_W-1:0]        req_dest_mac,
   input  logic [lbfd_pkg::PORT_W-1:0]       req_ingress_port,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [lbfd_pkg::MASK_W-1:0]       rsp_egress_mask,
   output logic [1:0]                        rsp_decision,
   output logic [1:0]                        rsp_learn_status,
   input  lbfd_pkg::cmd_type                 cmd,
   output lbfd_pkg::status_type              status
);

   localparam int AW    = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   // ports 1..PORTS, cut to the mask field
   function automatic logic [lbfd_pkg::MASK_W-1:0] all_mask();
      logic [lbfd_pkg::MASK_W-1:0] m;
      for (int i = 0; i < lbfd_pkg::MASK_W; i++) begin
         m[i] = (i < PORTS);
      end
      return m;
   endfunction

   function automatic logic [lbfd_pkg::MASK_W-1:0] port_bit(
      input logic [lbfd_pkg::PORT_W-1:0] p
   );
      logic [lbfd_pkg::MASK_W-1:0] m;
      for (int i = 0; i < lbfd_pkg::MASK_W; i++) begin
         m[i] = (int'(p) == i + 1) && (i < PORTS);
      end
      return m;
   endfunction

   // captured header
   logic [lbfd_pkg::MAC_W-1:0]  src_ff;
   logic [lbfd_pkg::PORT_W-1:0] ing_ff;
   logic                        bcast_ff;
   logic                        same_ff;

   // table bookkeeping; entries fill in order and are never freed
   logic [CNT_W-1:0] count_ff;
   logic [AW-1:0]    ptr_ff;
   logic             rd_valid_ff;
   logic [AW-1:0]    rd_idx_ff;

   // scan results
   logic                        src_hit_ff;
   logic [AW-1:0]               src_idx_ff;
   logic [lbfd_pkg::PORT_W-1:0] src_port_ff;
   logic                        dst_hit_ff;
   logic [lbfd_pkg::PORT_W-1:0] dst_port_ff;
   logic [lbfd_pkg::MAC_W-1:0]  dst_ff;

   // result register
   logic                          rsp_valid_ff;
   logic [lbfd_pkg::MASK_W-1:0]   mask_ff;
   lbfd_pkg::decision_type        dec_ff;
   lbfd_pkg::learn_type           lrn_ff;

   logic [lbfd_pkg::ENTRY_W-1:0] rd_data;
   logic [lbfd_pkg::MAC_W-1:0]   rd_mac;
   logic [lbfd_pkg::PORT_W-1:0]  rd_port;
   logic                         full;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   lbfd_pkg::learn_type          lrn;
   lbfd_pkg::decision_type       dec;
   logic [lbfd_pkg::MASK_W-1:0]  mask;

   lbfd_ram #(
      .WIDTH (lbfd_pkg::ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({src_ff, ing_ff}),
      .rd_en   (cmd.scan_rd),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   assign rd_mac  = rd_data[lbfd_pkg::ENTRY_W-1:lbfd_pkg::PORT_W];
   assign rd_port = rd_data[lbfd_pkg::PORT_W-1:0];
   assign full    = (count_ff == CNT_W'(TABLE_ENTRIES));

   // learn, then resolve destination against the table as it stands after learning
   always_comb begin
      if (src_hit_ff) begin
         lrn = (src_port_ff == ing_ff) ? lbfd_pkg::LRN_KNOWN : lbfd_pkg::LRN_MOVED;
      end else begin
         lrn = full ? lbfd_pkg::LRN_FULL : lbfd_pkg::LRN_ADDED;
      end

      priority if (bcast_ff) begin
         dec  = lbfd_pkg::DEC_BCAST;
         mask = all_mask() & ~port_bit(ing_ff);
      end else if (same_ff) begin
         // destination is the source just learned on ingress
         if (lrn != lbfd_pkg::LRN_FULL) begin
            dec  = lbfd_pkg::DEC_FILTER;
            mask = '0;
         end else begin
            dec  = lbfd_pkg::DEC_UNKNOWN;
            mask = all_mask() & ~port_bit(ing_ff);
         end
      end else if (!dst_hit_ff) begin
         dec  = lbfd_pkg::DEC_UNKNOWN;
         mask = all_mask() & ~port_bit(ing_ff);
      end else if (dst_port_ff == ing_ff) begin
         dec  = lbfd_pkg::DEC_FILTER;
         mask = '0;
      end else begin
         dec  = lbfd_pkg::DEC_FORWARD;
         mask = port_bit(dst_port_ff);
      end
   end

   assign wr_en   = cmd.commit &&
                    (lrn == lbfd_pkg::LRN_MOVED || lrn == lbfd_pkg::LRN_ADDED);
   assign wr_addr = src_hit_ff ? src_idx_ff : count_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.scan_rd;
         if (cmd.commit && lrn == lbfd_pkg::LRN_ADDED) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         src_ff     <= req_src_mac;
         dst_ff     <= req_dest_mac;
         ing_ff     <= req_ingress_port;
         bcast_ff   <= (req_dest_mac == lbfd_pkg::BROADCAST_MAC);
         same_ff    <= (req_dest_mac == req_src_mac);
         ptr_ff     <= '0;
         src_hit_ff <= 1'b0;
         dst_hit_ff <= 1'b0;
      end else begin
         if (cmd.scan_rd) begin
            ptr_ff <= ptr_ff + AW'(1);
         end
         if (rd_valid_ff && rd_mac == src_ff) begin
            src_hit_ff  <= 1'b1;
            src_idx_ff  <= rd_idx_ff;
            src_port_ff <= rd_port;
         end
         if (rd_valid_ff && rd_mac == dst_ff) begin
            dst_hit_ff  <= 1'b1;
            dst_port_ff <= rd_port;
         end
      end
      rd_idx_ff <= ptr_ff;
      if (cmd.commit) begin
         mask_ff <= mask;
         dec_ff  <= dec;
         lrn_ff  <= lrn;
      end
   end

   assign status.count_zero = (count_ff == '0);
   assign status.ptr_last   = ((CNT_W'(ptr_ff) + CNT_W'(1)) == count_ff);
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.table_full = full;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_egress_mask  = mask_ff;
   assign rsp_decision     = dec_ff;
   assign rsp_learn_status = lrn_ff;

endmodule

>>> design/learning_bridge_forward_decision_unit.sv
// Top level of the learning bridge forward decision unit.
//
// Usage:
//  - Request channel (req_*): one frame header per transfer: source MAC,
//    destination MAC, ingress port. A transfer happens on a clock edge with
//    req_valid high and req_stall low.
//  - Response channel (rsp_*): one decision per header: egress port mask,
//    decision code and learn status, in request order.
//  - The MAC table is one RAM of TABLE_ENTRIES entries (MAC plus port),
//    filled in order and never aged. Each header scans the N filled entries,
//    one RAM read per cycle, matching source and destination on the same
//    read. That single read port sets the timing.
//  - Each request passes through scan, drain and decide states (straight to
//    decide when the table is empty); no new request is taken until its
//    result is committed and the unit is back in idle.
//  - Reset (synchronous, active high) empties the table at once by zeroing
//    the fill count; no clearing pass, requests are taken right after.
//  - A stalled response is held in the output register; the unit still
//    accepts and scans the next header, then waits before its update and
//    result load until the output register frees up.
module learning_bridge_forward_decision_unit #(
   parameter int PORTS         = 4,
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [lbfd_pkg::MAC_W-1:0]   req_src_mac,
   input  logic [lbfd_pkg::MAC_W-1:0]   req_dest_mac,
   input  logic [lbfd_pkg::PORT_W-1:0]  req_ingress_port,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [lbfd_pkg::MASK_W-1:0]  rsp_egress_mask,
   output logic [1:0]                   rsp_decision,
   output logic [1:0]                   rsp_learn_status
);

   lbfd_pkg::cmd_type    cmd;
   lbfd_pkg::status_type status;

   // sequencer
   lbfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // table, compare and result register
   lbfd_dp #(
      .PORTS         (PORTS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_src_mac      (req_src_mac),
      .req_dest_mac     (req_dest_mac),
      .req_ingress_port (req_ingress_port),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_egress_mask  (rsp_egress_mask),
      .rsp_decision     (rsp_decision),
      .rsp_learn_status (rsp_learn_status),
      .cmd              (cmd),
      .status           (status)
   );

   // a new response only ever comes from a commit
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.commit))
      else $error("response raised without a commit");

   // commit never overwrites a response that is still stalled
   assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("commit while result register busy");

   // entries are never freed: a full table stays full
   assert property (@(posedge clock) disable iff (reset)
      status.table_full |=> status.table_full)
      else $error("table fill count went down");

   // no header is taken while a scan or update is in flight
   assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_rd || cmd.commit) |-> req_stall)
      else $error("request accepted during scan or update");

endmodule

>>> verif/lbfd_decision_checker.sv
`timescale 1ns / 1ps
// Checker for the forward decision unit: predicts each decision and compares it.
module lbfd_decision_checker #(
   parameter int PORTS         = 4,
   parameter int TABLE_ENTRIES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_stall,
   input  logic [lbfd_pkg::MAC_W-1:0]    req_src_mac,
   input  logic [lbfd_pkg::MAC_W-1:0]    req_dest_mac,
   input  logic [lbfd_pkg::PORT_W-1:0]   req_ingress_port,
   input  logic                          rsp_valid,
   input  logic                          rsp_stall,
   input  logic [lbfd_pkg::MASK_W-1:0]   rsp_egress_mask,
   input  logic [1:0]                    rsp_decision,
   input  logic [1:0]                    rsp_learn_status,
   output int                            mismatch_count,
   output int                            decisions_in_flight
);

   typedef logic [lbfd_pkg::MAC_W-1:0]  mac_type;
   typedef logic [lbfd_pkg::PORT_W-1:0] port_type;
   typedef logic [lbfd_pkg::MASK_W-1:0] mask_type;

   typedef struct packed {
      mask_type               egress_mask;
      lbfd_pkg::decision_type decision;
      lbfd_pkg::learn_type    learn_status;
   } frame_verdict_type;

   localparam mask_type ALL_PORTS = mask_type'((64'd1 << PORTS) - 64'd1);

   // shadow MAC table
   mac_type  station_mac  [TABLE_ENTRIES];
   port_type station_port [TABLE_ENTRIES];
   logic     station_used [TABLE_ENTRIES];

   frame_verdict_type pending_decisions[$];

   function automatic mask_type port_bit(input port_type p);
      if (p >= 1 && p <= PORTS) return mask_type'(64'd1 << (p - 1));
      return '0;
   endfunction

   function automatic int find_station(input mac_type mac);
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (station_used[i] && station_mac[i] == mac) return i;
      return -1;
   endfunction

   // learn the source first, then resolve the destination
   function automatic frame_verdict_type forward_decision(input mac_type  src,
                                                          input mac_type  dst,
                                                          input port_type ingress);
      frame_verdict_type v;
      int                hit;
      int                slot;
      hit = find_station(src);
      if (hit >= 0) begin
         if (station_port[hit] != ingress) begin
            station_port[hit] = ingress;
            v.learn_status = lbfd_pkg::LRN_MOVED;
         end else begin
            v.learn_status = lbfd_pkg::LRN_KNOWN;
         end
      end else begin
         slot = -1;
         for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++)
            if (!station_used[i]) slot = i;
         if (slot >= 0) begin
            station_used[slot] = 1'b1;
            station_mac[slot]  = src;
            station_port[slot] = ingress;
            v.learn_status     = lbfd_pkg::LRN_ADDED;
         end else begin
            v.learn_status = lbfd_pkg::LRN_FULL;
         end
      end

      if (dst == lbfd_pkg::BROADCAST_MAC) begin
         v.decision    = lbfd_pkg::DEC_BCAST;
         v.egress_mask = ALL_PORTS & ~port_bit(ingress);
      end else begin
         hit = find_station(dst);
         if (hit < 0) begin
            v.decision    = lbfd_pkg::DEC_UNKNOWN;
            v.egress_mask = ALL_PORTS & ~port_bit(ingress);
         end else if (station_port[hit] == ingress) begin
            v.decision    = lbfd_pkg::DEC_FILTER;
            v.egress_mask = '0;
         end else begin
            v.decision    = lbfd_pkg::DEC_FORWARD;
            v.egress_mask = port_bit(station_port[hit]);
         end
      end
      return v;
   endfunction

   // Response is checked before the request of the same edge is predicted:
   // a response can never belong to a header taken on that same edge.
   always @(posedge clock) begin
      frame_verdict_type exp_v;
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) station_used[i] = 1'b0;
         pending_decisions.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_decisions.size() == 0) begin
               $error("decision transfer with none outstanding: mask %h decision %0d learn %0d",
                      rsp_egress_mask, rsp_decision, rsp_learn_status);
               mismatch_count++;
            end else begin
               exp_v = pending_decisions.pop_front();
               if (rsp_egress_mask !== exp_v.egress_mask) begin
                  $error("egress_mask: expected %h, got %h", exp_v.egress_mask, rsp_egress_mask);
                  mismatch_count++;
               end
               if (rsp_decision !== exp_v.decision) begin
                  $error("decision: expected %0d, got %0d", exp_v.decision, rsp_decision);
                  mismatch_count++;
               end
               if (rsp_learn_status !== exp_v.learn_status) begin
                  $error("learn_status: expected %0d, got %0d",
                         exp_v.learn_status, rsp_learn_status);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            pending_decisions.push_back(
               forward_decision(req_src_mac, req_dest_mac, req_ingress_port));
      end
      decisions_in_flight = pending_decisions.size();
   end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Top of the forward decision unit testbench: clock, reset, stimulus and verdict.
module testbench;

   localparam int PORTS         = 4;
   localparam int TABLE_ENTRIES = 64;
   localparam int POOL_SIZE     = 128;

   typedef logic [lbfd_pkg::MAC_W-1:0]  mac_type;
   typedef logic [lbfd_pkg::PORT_W-1:0] port_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [lbfd_pkg::MAC_W-1:0]    req_src_mac = '0;
   logic [lbfd_pkg::MAC_W-1:0]    req_dest_mac = '0;
   logic [lbfd_pkg::PORT_W-1:0]   req_ingress_port = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [lbfd_pkg::MASK_W-1:0]   rsp_egress_mask;
   logic [1:0]                    rsp_decision;
   logic [1:0]                    rsp_learn_status;

   int mismatch_count;
   int decisions_in_flight;

   // Station addresses reused by the random part so that sources get
   // learned, revisited, moved, and (once the pool outgrows the table) refused.
   mac_type station_pool [POOL_SIZE];

   // calm phases: no idling on that side for a stretch of transfers
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   learning_bridge_forward_decision_unit #(
      .PORTS         (PORTS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_src_mac      (req_src_mac),
      .req_dest_mac     (req_dest_mac),
      .req_ingress_port (req_ingress_port),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_egress_mask  (rsp_egress_mask),
      .rsp_decision     (rsp_decision),
      .rsp_learn_status (rsp_learn_status)
   );

   lbfd_decision_checker #(
      .PORTS         (PORTS),
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) checker_i (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_src_mac         (req_src_mac),
      .req_dest_mac        (req_dest_mac),
      .req_ingress_port    (req_ingress_port),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_egress_mask     (rsp_egress_mask),
      .rsp_decision        (rsp_decision),
      .rsp_learn_status    (rsp_learn_status),
      .mismatch_count      (mismatch_count),
      .decisions_in_flight (decisions_in_flight)
   );

   function automatic mac_type random_mac();
      return mac_type'({$urandom(), $urandom()});
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   // Valid stays high across back-to-back headers, so it is only lowered when
   // a gap is drawn.
   task automatic send_header(input mac_type  src,
                              input mac_type  dst,
                              input port_type ingress);
      int gap;
      if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_src_mac      <= src;
      req_dest_mac     <= dst;
      req_ingress_port <= ingress;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Random header over the first pool_used pool stations. Mostly in-range
   // ports; some out-of-range ones (0, 5..7) and some fully random addresses.
   task automatic send_random_header(input int pool_used);
      mac_type  src;
      mac_type  dst;
      port_type ingress;
      int       pick;
      src = ($urandom_range(0, 19) == 0) ? random_mac()
                                         : station_pool[$urandom_range(0, pool_used - 1)];
      pick = $urandom_range(0, 99);
      if (pick < 10)      dst = lbfd_pkg::BROADCAST_MAC;
      else if (pick < 22) dst = src;
      else if (pick < 80) dst = station_pool[$urandom_range(0, pool_used - 1)];
      else                dst = random_mac();
      ingress = ($urandom_range(0, 6) == 0) ? port_type'($urandom_range(0, 7))
                                            : port_type'($urandom_range(1, PORTS));
      send_header(src, dst, ingress);
   endtask

   // Result side: for every transfer draw a random stall, applied whether or
   // not a result is waiting, so it lands on every phase of a scan.
   initial begin
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
         hold = rsp_calm ? 0 : $urandom_range(0, 15);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // Slowest correct run is about 1600 headers, each with a full scan plus the
   // longest gap and stall, well under 0.4 ms; this bound is several times that.
   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      mac_type s1, s2, s3, s4, s5, s6, s7, s8, unk1, unk2;
      for (int i = 0; i < POOL_SIZE; i++) station_pool[i] = random_mac();
      s1   = 48'h0200_0000_0001;
      s2   = 48'h0200_0000_0002;
      s3   = 48'h0200_0000_0003;
      s4   = 48'h0200_0000_0004;
      s5   = 48'h0200_0000_0005;
      s6   = 48'h0200_0000_0006;
      s7   = 48'h0200_0000_0007;
      s8   = 48'h0200_0000_0008;
      unk1 = 48'h0A00_0000_00F1;
      unk2 = 48'h0A00_0000_00F2;

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // --- directed part ---
      send_header('0, lbfd_pkg::BROADCAST_MAC, 3'd1);   // all-zero source, broadcast
      send_header(s1, '0, 3'd2);               // forward to port 1
      send_header(s1, s1, 3'd2);               // known source, same dest: filtered
      send_header(s1, '0, 3'd3);               // station move 2 -> 3
      send_header('0, s1, 3'd1);               // forward to moved port 3
      send_header(s2, unk1, 3'd4);             // unknown dest floods
      send_header(s3, s3, 3'd1);               // new source equals dest: filtered
      send_header(lbfd_pkg::BROADCAST_MAC, s2, 3'd2);   // all-ones learned as a source
      send_header(s2, lbfd_pkg::BROADCAST_MAC, 3'd4);   // still a broadcast flood
      send_header(s4, '0, 3'd1);               // dest on ingress port: filtered
      send_header(s5, unk2, 3'd0);             // port 0 learned, flood all ports
      send_header(s6, s5, 3'd3);               // unicast to port 0: empty mask
      send_header(s7, lbfd_pkg::BROADCAST_MAC, 3'd7);   // port 7 ingress broadcast
      send_header(s5, s7, 3'd5);               // move 0 -> 5, forward to port 7
      send_header(s7, s5, 3'd7);               // forward to port 5
      send_header(s8, s8, 3'd6);               // out-of-range port filter
      send_header(48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 3'd4);
      send_header(48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 3'd2);
      send_header(s1, s4, 3'd1);               // move 3 -> 1, then filtered
      send_header(lbfd_pkg::BROADCAST_MAC, lbfd_pkg::BROADCAST_MAC, 3'd1);
      send_header(s2, s1, 3'd4);               // forward to port 1

      // --- random part ---
      // First a pool that fits in the table: adds, moves, hits.
      repeat (700) send_random_header(32);
      // Then the whole pool: the table fills and new sources are refused,
      // while stored stations keep moving and forwarding.
      repeat (800) send_random_header(POOL_SIZE);

      req_valid <= 1'b0;

      // drain, then allow one full scan for any stray result
      while (decisions_in_flight != 0) @(posedge clock);
      repeat (TABLE_ENTRIES + 8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/lbfd_pkg.sv
design/lbfd_ram.sv
design/lbfd_ctrl.sv
design/lbfd_dp.sv
design/learning_bridge_forward_decision_unit.sv
verif/lbfd_decision_checker.sv
verif/testbench.sv
